/* hdl/rnet_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rnet_pkg
// Shared types, codes and sizes for the running note expiry tracker.
// ----------------------------------------------------------------------------
package rnet_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int REM_W       = 16;
    localparam int DELTA_W     = 24;
    localparam int IN_DATA_W   = 48;
    localparam int OUT_DATA_W  = 40;

    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_START   = 2'd1,
        CMD_ADVANCE = 2'd2,
        CMD_FLUSH   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        KIND_OFF   = 3'd0,
        KIND_ON    = 3'd1,
        KIND_RENEW = 3'd2,
        KIND_REST  = 3'd3,
        KIND_DONE  = 3'd4
    } t_kind;

    // commands from the controller to the datapath
    typedef struct packed {
        logic  load_in;      // capture input transaction, pending/acc <= delta, idx <= 0
        logic  clear_cnt;    // empty the table
        logic  idx_clr;
        logic  idx_inc;
        logic  rd_en;        // read table entry into the read registers
        logic  rd_last;      // read address is the count instead of idx
        logic  wr_sub;       // rem[idx] <= read rem - step
        logic  wr_len;       // rem[idx] <= length
        logic  wr_move;      // entry[idx] <= read registers
        logic  append;       // entry[count] <= input, count++ if room
        logic  cnt_dec;
        logic  acc_min_init; // acc <= pending + 1
        logic  acc_min;
        logic  acc_max;
        logic  pend_from_acc;
        logic  batch;        // step <= acc, pending -= acc
        logic  step_clr;
        logic  step_pend;    // step <= pending
        logic  emit;
        t_kind emit_kind;
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        t_cmd cmd;
        logic idx_lt_cnt;
        logic cnt_full;
        logic pitch_zero;
        logic match;
        logic rem_zero;
        logic acc_gt_pend;
        logic out_free;
    } t_dp_sts;

endpackage
`default_nettype wire

/* hdl/rnet_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rnet_dp
// Datapath: note table memory, scan index, count, time accumulators and the
// output register.
// ----------------------------------------------------------------------------
module rnet_dp (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [1:0]                   i_in_cmd,
    input  wire logic [rnet_pkg::IN_DATA_W-1:0] i_in_data,
    input  wire rnet_pkg::t_dp_cmd            i_cmd,
    output rnet_pkg::t_dp_sts                 o_sts,
    input  wire logic                         i_m_tready,
    output logic                              o_m_tvalid,
    output logic [rnet_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    output logic [2:0]                        o_m_tuser,
    output logic                              o_m_tlast
);
    import rnet_pkg::*;

    // note table
    logic [3:0]       mem_ch  [TABLE_DEPTH];
    logic [6:0]       mem_pt  [TABLE_DEPTH];
    logic [REM_W-1:0] mem_rem [TABLE_DEPTH];

    logic [1:0]         r_cmd;
    logic [3:0]         r_ch;
    logic [6:0]         r_pitch;
    logic [7:0]         r_len;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_idx;
    logic [DELTA_W-1:0] r_pending;
    logic [DELTA_W:0]   r_acc;
    logic [DELTA_W-1:0] r_step;
    logic [3:0]         r_rd_ch;
    logic [6:0]         r_rd_pt;
    logic [REM_W-1:0]   r_rd_rem;

    logic               r_out_valid;
    logic [2:0]         r_out_kind;
    logic [3:0]         r_out_ch;
    logic [6:0]         r_out_pt;
    logic [DELTA_W-1:0] r_out_delta;
    logic               r_out_trk;
    logic               r_out_last;

    logic [DELTA_W:0]   rem_ext;
    logic               out_free;
    logic [ADDR_W-1:0]  rd_addr;
    logic [REM_W-1:0]   rem_sub;

    assign rem_ext  = {{(DELTA_W + 1 - REM_W){1'b0}}, r_rd_rem};
    assign out_free = !r_out_valid || i_m_tready;
    assign rd_addr  = i_cmd.rd_last ? r_count[ADDR_W-1:0] : r_idx[ADDR_W-1:0];
    assign rem_sub  = r_rd_rem - r_step[REM_W-1:0];

    // status
    always_comb begin
        o_sts.cmd         = t_cmd'(r_cmd);
        o_sts.idx_lt_cnt  = r_idx < r_count;
        o_sts.cnt_full    = r_count == CNT_W'(TABLE_DEPTH);
        o_sts.pitch_zero  = r_pitch == 7'd0;
        o_sts.match       = r_rd_pt == r_pitch;
        o_sts.rem_zero    = r_rd_rem == '0;
        o_sts.acc_gt_pend = r_acc > {1'b0, r_pending};
        o_sts.out_free    = out_free;
    end

    // table read and write
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_ch  <= mem_ch[rd_addr];
            r_rd_pt  <= mem_pt[rd_addr];
            r_rd_rem <= mem_rem[rd_addr];
        end
        if (i_cmd.wr_sub) begin
            mem_rem[r_idx[ADDR_W-1:0]] <= rem_sub;
        end else if (i_cmd.wr_len) begin
            mem_rem[r_idx[ADDR_W-1:0]] <= {{(REM_W - 8){1'b0}}, r_len};
        end else if (i_cmd.wr_move) begin
            mem_ch[r_idx[ADDR_W-1:0]]  <= r_rd_ch;
            mem_pt[r_idx[ADDR_W-1:0]]  <= r_rd_pt;
            mem_rem[r_idx[ADDR_W-1:0]] <= r_rd_rem;
        end else if (i_cmd.append && !o_sts.cnt_full) begin
            mem_ch[r_count[ADDR_W-1:0]]  <= r_ch;
            mem_pt[r_count[ADDR_W-1:0]]  <= r_pitch;
            mem_rem[r_count[ADDR_W-1:0]] <= {{(REM_W - 8){1'b0}}, r_len};
        end
    end

    // input capture, index and time bookkeeping
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cmd     <= i_in_cmd;
            r_ch      <= i_in_data[3:0];
            r_pitch   <= i_in_data[10:4];
            r_len     <= i_in_data[18:11];
            r_pending <= i_in_data[42:19];
            r_acc     <= {1'b0, i_in_data[42:19]};
        end else if (i_cmd.acc_min_init) begin
            r_acc <= {1'b0, r_pending} + 1'b1;
        end else if (i_cmd.acc_min) begin
            if (rem_ext < r_acc) begin
                r_acc <= rem_ext;
            end
        end else if (i_cmd.acc_max) begin
            if (rem_ext > r_acc) begin
                r_acc <= rem_ext;
            end
        end else if (i_cmd.pend_from_acc) begin
            r_pending <= r_acc[DELTA_W-1:0];
        end else if (i_cmd.batch) begin
            r_step    <= r_acc[DELTA_W-1:0];
            r_pending <= r_pending - r_acc[DELTA_W-1:0];
        end
        if (i_cmd.step_clr) begin
            r_step <= '0;
        end else if (i_cmd.step_pend) begin
            r_step <= r_pending;
        end
        if (i_cmd.load_in || i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clear_cnt) begin
            r_count <= '0;
        end else if (i_cmd.append && !o_sts.cnt_full) begin
            r_count <= r_count + 1'b1;
        end else if (i_cmd.cnt_dec) begin
            r_count <= r_count - 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_kind  <= i_cmd.emit_kind;
            r_out_ch    <= '0;
            r_out_pt    <= '0;
            r_out_delta <= '0;
            r_out_trk   <= 1'b0;
            r_out_last  <= 1'b1;
            case (i_cmd.emit_kind)
                KIND_OFF: begin
                    r_out_ch    <= r_rd_ch;
                    r_out_pt    <= r_rd_pt;
                    r_out_delta <= r_step;
                    r_out_last  <= 1'b0;
                end
                KIND_ON: begin
                    r_out_ch  <= r_ch;
                    r_out_pt  <= r_pitch;
                    r_out_trk <= !o_sts.cnt_full;
                end
                KIND_RENEW: begin
                    r_out_ch <= r_rd_ch;
                    r_out_pt <= r_pitch;
                end
                KIND_REST: begin
                    r_out_ch <= r_ch;
                end
                KIND_DONE: begin
                    r_out_delta <= r_pending;
                end
                default: begin
                    r_out_last <= 1'b1;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0, r_out_trk, r_out_delta, r_out_pt, r_out_ch};
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_last;

endmodule
`default_nettype wire

/* hdl/rnet_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rnet_ctrl
// Controller: sequences the table scans for start, advance and flush.
// ----------------------------------------------------------------------------
module rnet_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire rnet_pkg::t_dp_sts i_sts,
    output rnet_pkg::t_dp_cmd      o_cmd
);
    import rnet_pkg::*;

    typedef enum logic [22:0] {
        S_IDLE       = 23'b1 << 0,
        S_DISPATCH   = 23'b1 << 1,
        S_EMIT_REST  = 23'b1 << 2,
        S_FIND_RD    = 23'b1 << 3,
        S_FIND_CHK   = 23'b1 << 4,
        S_EMIT_RENEW = 23'b1 << 5,
        S_APPEND     = 23'b1 << 6,
        S_MAX_RD     = 23'b1 << 7,
        S_MAX_CHK    = 23'b1 << 8,
        S_MIN_START  = 23'b1 << 9,
        S_MIN_RD     = 23'b1 << 10,
        S_MIN_CHK    = 23'b1 << 11,
        S_MIN_END    = 23'b1 << 12,
        S_SUB_RD     = 23'b1 << 13,
        S_SUB_WR     = 23'b1 << 14,
        S_EXP_RD     = 23'b1 << 15,
        S_EXP_CHK    = 23'b1 << 16,
        S_EXP_EMIT   = 23'b1 << 17,
        S_MOVE_RD    = 23'b1 << 18,
        S_MOVE_WR    = 23'b1 << 19,
        S_FSUB_RD    = 23'b1 << 20,
        S_FSUB_WR    = 23'b1 << 21,
        S_EMIT_DONE  = 23'b1 << 22
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = r_state == S_IDLE;

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.emit_kind = KIND_DONE;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_sts.cmd)
                    CMD_CLEAR: begin
                        o_cmd.clear_cnt = 1'b1;
                        n_state = S_IDLE;
                    end
                    CMD_START: begin
                        n_state = i_sts.pitch_zero ? S_EMIT_REST : S_FIND_RD;
                    end
                    CMD_ADVANCE: n_state = S_MIN_START;
                    CMD_FLUSH:   n_state = S_MAX_RD;
                    default:     n_state = S_IDLE;
                endcase
            end
            S_EMIT_REST: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.emit_kind = KIND_REST;
                    n_state = S_IDLE;
                end
            end
            // look for a held pitch
            S_FIND_RD: begin
                if (i_sts.idx_lt_cnt) begin
                    o_cmd.rd_en = 1'b1;
                    n_state = S_FIND_CHK;
                end else begin
                    n_state = S_APPEND;
                end
            end
            S_FIND_CHK: begin
                if (i_sts.match) begin
                    o_cmd.wr_len = 1'b1;
                    n_state = S_EMIT_RENEW;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = S_FIND_RD;
                end
            end
            S_EMIT_RENEW: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.emit_kind = KIND_RENEW;
                    n_state = S_IDLE;
                end
            end
            S_APPEND: begin
                if (i_sts.out_free) begin
                    o_cmd.append = 1'b1;
                    o_cmd.emit = 1'b1;
                    o_cmd.emit_kind = KIND_ON;
                    n_state = S_IDLE;
                end
            end
            // flush: stretch pending to the longest note
            S_MAX_RD: begin
                if (i_sts.idx_lt_cnt) begin
                    o_cmd.rd_en = 1'b1;
                    n_state = S_MAX_CHK;
                end else begin
                    o_cmd.pend_from_acc = 1'b1;
                    n_state = S_MIN_START;
                end
            end
            S_MAX_CHK: begin
                o_cmd.acc_max = 1'b1;
                o_cmd.idx_inc = 1'b1;
                n_state = S_MAX_RD;
            end
            // find the smallest remaining time
            S_MIN_START: begin
                o_cmd.acc_min_init = 1'b1;
                o_cmd.idx_clr = 1'b1;
                n_state = S_MIN_RD;
            end
            S_MIN_RD: begin
                if (i_sts.idx_lt_cnt) begin
                    o_cmd.rd_en = 1'b1;
                    n_state = S_MIN_CHK;
                end else begin
                    n_state = S_MIN_END;
                end
            end
            S_MIN_CHK: begin
                o_cmd.acc_min = 1'b1;
                o_cmd.idx_inc = 1'b1;
                n_state = S_MIN_RD;
            end
            S_MIN_END: begin
                o_cmd.idx_clr = 1'b1;
                if (i_sts.acc_gt_pend) begin
                    o_cmd.step_pend = 1'b1;
                    n_state = S_FSUB_RD;
                end else begin
                    o_cmd.batch = 1'b1;
                    n_state = S_SUB_RD;
                end
            end
            // subtract the batch step from every entry
            S_SUB_RD: begin
                if (i_sts.idx_lt_cnt) begin
                    o_cmd.rd_en = 1'b1;
                    n_state = S_SUB_WR;
                end else begin
                    o_cmd.idx_clr = 1'b1;
                    n_state = S_EXP_RD;
                end
            end
            S_SUB_WR: begin
                o_cmd.wr_sub = 1'b1;
                o_cmd.idx_inc = 1'b1;
                n_state = S_SUB_RD;
            end
            // remove expired entries, last entry fills the hole
            S_EXP_RD: begin
                if (i_sts.idx_lt_cnt) begin
                    o_cmd.rd_en = 1'b1;
                    n_state = S_EXP_CHK;
                end else begin
                    n_state = S_MIN_START;
                end
            end
            S_EXP_CHK: begin
                if (i_sts.rem_zero) begin
                    n_state = S_EXP_EMIT;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = S_EXP_RD;
                end
            end
            S_EXP_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.emit_kind = KIND_OFF;
                    o_cmd.step_clr = 1'b1;
                    o_cmd.cnt_dec = 1'b1;
                    n_state = S_MOVE_RD;
                end
            end
            S_MOVE_RD: begin
                if (i_sts.idx_lt_cnt) begin
                    o_cmd.rd_en = 1'b1;
                    o_cmd.rd_last = 1'b1;
                    n_state = S_MOVE_WR;
                end else begin
                    n_state = S_EXP_RD;
                end
            end
            S_MOVE_WR: begin
                o_cmd.wr_move = 1'b1;
                n_state = S_EXP_CHK;
            end
            // subtract the leftover from every entry
            S_FSUB_RD: begin
                if (i_sts.idx_lt_cnt) begin
                    o_cmd.rd_en = 1'b1;
                    n_state = S_FSUB_WR;
                end else begin
                    n_state = S_EMIT_DONE;
                end
            end
            S_FSUB_WR: begin
                o_cmd.wr_sub = 1'b1;
                o_cmd.idx_inc = 1'b1;
                n_state = S_FSUB_RD;
            end
            S_EMIT_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.emit_kind = KIND_DONE;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

/* hdl/running_note_expiry_tracker.sv */
`default_nettype none
// Start scans the held entries for a matching pitch and stops early on a match.
// Advance accepts and decodes, then per expiry batch runs the minimum and subtract
// scans and examines or removes each entry, then a final minimum scan, leftover pass
// and done result, plus any output stalls.
// One transaction at a time; the single-port note table memory sets the rate.
// Reset (synchronous, active low) empties the table and the output register.
// ----------------------------------------------------------------------------
// running_note_expiry_tracker
// Table of sounding notes with renewal, note-on entry and timed note-off.
// ----------------------------------------------------------------------------
module running_note_expiry_tracker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    // channel[3:0], pitch[10:4], length[18:11], delta[42:19], zero fill
    input  wire logic [rnet_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // cmd[1:0]
    input  wire logic [1:0]                      i_s_tuser,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    // out_channel[3:0], out_pitch[10:4], out_delta[34:11], tracked[35], zero fill
    output logic [rnet_pkg::OUT_DATA_W-1:0]      o_m_tdata,
    // kind[2:0]
    output logic [2:0]                           o_m_tuser,
    output logic                                 o_m_tlast
);
    import rnet_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    rnet_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rnet_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_cmd   (i_s_tuser),
        .i_in_data  (i_s_tdata),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
`default_nettype wire
